FILE: rtl/ncg_pkg.sv
// ---------------------------------------------------------------------------
// ncg_pkg
// Shared types and constants of the neighbor cell counting grid: register
// indexes, reset values, controller states and the command/status bundles
// between controller and datapath.
// ---------------------------------------------------------------------------
package ncg_pkg;

    localparam int POS_W = 16;   // Q12.4 coordinate width
    localparam int CFG_W = 16;   // widest configuration register
    localparam int BIN_W = 7;    // cols_in_use / rows_in_use width
    localparam int IDX_W = 3;    // configuration register index width
    localparam int OUT_CELL_W = 6;
    localparam int OUT_PEAK_W = 16;

    localparam logic [IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CELL_WIDTH_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_CELL_WIDTH_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_COLS_IN_USE = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROWS_IN_USE = 3'd5;

    localparam logic [POS_W-1:0] ORIGIN_RESET     = 16'd0;
    localparam logic [POS_W-1:0] CELL_WIDTH_RESET = 16'd16;
    localparam logic [BIN_W-1:0] BINS_RESET       = 7'd64;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_NB_RD,
        ST_NB_WR,
        ST_DONE
    } ncg_state_t;

    typedef enum logic [1:0] {
        OUT_ADD,
        OUT_REJECT,
        OUT_CLEAR
    } ncg_out_t;

    typedef struct packed {
        logic     clr_start;  // restart the clearing sweep, zero the peak
        logic     clr_step;   // write zero at the sweep address and advance
        logic     load;       // capture the point and start both divisions
        logic     nb_read;    // read the current neighbor cell
        logic     nb_write;   // write back the neighbor, advance to the next
        logic     out_load;   // load the result register
        ncg_out_t out_sel;
    } ncg_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic reject;
        logic nb_last;
    } ncg_sts_t;

endpackage

FILE: rtl/ncg_ram.sv
// ---------------------------------------------------------------------------
// ncg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ncg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ncg_div.sv
// ---------------------------------------------------------------------------
// ncg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ncg_div
    import ncg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [POS_W-1:0] divisor,
    output logic             busy,
    output logic [POS_W-1:0] quotient
);

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0] dq_reg, dq_next;
    logic [POS_W-1:0] dv_reg, dv_next;
    logic [POS_W:0]   rem_shift;
    logic             ge;

    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[POS_W-1]};
        ge        = (rem_shift >= {1'b0, dv_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dv_next   = dv_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            dv_next   = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = ge ? POS_W'(rem_shift - {1'b0, dv_reg}) : rem_shift[POS_W-1:0];
            dq_next  = {dq_reg[POS_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(POS_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dv_reg  <= dv_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

FILE: rtl/ncg_ctrl.sv
// ---------------------------------------------------------------------------
// ncg_ctrl
// Controller: sequences the clearing sweep, the divisions, the nine
// read-modify-write steps of the neighborhood and the result register.
// ---------------------------------------------------------------------------
module ncg_ctrl
    import ncg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     mode,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  ncg_sts_t sts,
    output ncg_cmd_t cmd
);

    ncg_state_t state_reg, state_next;
    ncg_out_t   kind_reg, kind_next;
    logic       clr_item_reg, clr_item_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        clr_item_next = clr_item_reg;
        cmd           = '0;
        cmd.out_sel   = kind_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    // the sweep after reset delivers no beat
                    state_next    = clr_item_reg ? ST_DONE : ST_IDLE;
                    kind_next     = OUT_CLEAR;
                    clr_item_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_CLEAR)
                    begin
                        cmd.clr_start = 1'b1;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.reject)
                    begin
                        kind_next  = OUT_REJECT;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        kind_next  = OUT_ADD;
                        state_next = ST_NB_RD;
                    end
                end
            end
            ST_NB_RD:
            begin
                cmd.nb_read = 1'b1;
                state_next  = ST_NB_WR;
            end
            ST_NB_WR:
            begin
                cmd.nb_write = 1'b1;
                state_next   = sts.nb_last ? ST_DONE : ST_NB_RD;
            end
            ST_DONE:
            begin
                // hold until the previous beat has left the result register
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            kind_reg      <= OUT_CLEAR;
            clr_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            clr_item_reg  <= clr_item_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while a beat waits");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");
`endif

endmodule

FILE: rtl/ncg_dp.sv
// ---------------------------------------------------------------------------
// ncg_dp
// Datapath: configuration registers, the two coordinate dividers, the count
// RAM with its clearing sweep, the neighborhood walk, the peak and the result
// register.
// ---------------------------------------------------------------------------
module ncg_dp
    import ncg_pkg::*;
#(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic [POS_W-1:0]      x_pos,
    input  logic [POS_W-1:0]      y_pos,
    input  ncg_cmd_t              cmd,
    output ncg_sts_t              sts,
    output logic [OUT_CELL_W-1:0] cell_col,
    output logic [OUT_CELL_W-1:0] cell_row,
    output logic [OUT_PEAK_W-1:0] peak_count,
    output logic                  rejected
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW    = POS_W + 1;

    // configuration
    logic [POS_W-1:0] origin_x_reg, origin_y_reg;
    logic [POS_W-1:0] cell_width_x_reg, cell_width_y_reg;
    logic [BIN_W-1:0] cols_in_use_reg, rows_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= ORIGIN_RESET;
            origin_y_reg     <= ORIGIN_RESET;
            cell_width_x_reg <= CELL_WIDTH_RESET;
            cell_width_y_reg <= CELL_WIDTH_RESET;
            cols_in_use_reg  <= BINS_RESET;
            rows_in_use_reg  <= BINS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                REG_CELL_WIDTH_X: cell_width_x_reg <= cfg_data;
                REG_CELL_WIDTH_Y: cell_width_y_reg <= cfg_data;
                REG_COLS_IN_USE:  cols_in_use_reg  <= cfg_data[BIN_W-1:0];
                REG_ROWS_IN_USE:  rows_in_use_reg  <= cfg_data[BIN_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [EW-1:0] cols_lim, rows_lim;

    assign cols_lim = (EW'(cols_in_use_reg) > EW'(MAX_COLS)) ? EW'(MAX_COLS)
                                                             : EW'(cols_in_use_reg);
    assign rows_lim = (EW'(rows_in_use_reg) > EW'(MAX_ROWS)) ? EW'(MAX_ROWS)
                                                             : EW'(rows_in_use_reg);

    // division
    logic             bad_x_reg, bad_y_reg;
    logic             busy_x, busy_y;
    logic [POS_W-1:0] qx, qy;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bad_x_reg <= (x_pos < origin_x_reg) || (cell_width_x_reg == '0);
            bad_y_reg <= (y_pos < origin_y_reg) || (cell_width_y_reg == '0);
        end
    end

    ncg_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (x_pos - origin_x_reg),
        .divisor  (cell_width_x_reg),
        .busy     (busy_x),
        .quotient (qx)
    );

    ncg_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (y_pos - origin_y_reg),
        .divisor  (cell_width_y_reg),
        .busy     (busy_y),
        .quotient (qy)
    );

    logic reject;

    assign reject = bad_x_reg || bad_y_reg
                 || (EW'(qx) >= cols_lim) || (EW'(qy) >= rows_lim);

    // neighborhood walk, column offset outer, row offset inner
    logic [1:0]    dc_reg, dc_next, dr_reg, dr_next;
    logic [EW-1:0] nb_c, nb_r;
    logic          nb_ok;
    logic [AW-1:0] nb_addr;

    assign nb_c  = EW'(qx) + EW'(dc_reg) - EW'(1);
    assign nb_r  = EW'(qy) + EW'(dr_reg) - EW'(1);
    // an offset below zero wraps to all ones and fails the compare
    assign nb_ok = (nb_c < cols_lim) && (nb_r < rows_lim);
    assign nb_addr = AW'(AW'(nb_r[RW-1:0]) * AW'(MAX_COLS)) + AW'(nb_c[CW-1:0]);

    always_comb
    begin
        dc_next = dc_reg;
        dr_next = dr_reg;
        if (cmd.load)
        begin
            dc_next = '0;
            dr_next = '0;
        end
        else if (cmd.nb_write)
        begin
            if (dr_reg == 2'd2)
            begin
                dr_next = '0;
                dc_next = dc_reg + 1'b1;
            end
            else
            begin
                dr_next = dr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dc_reg <= dc_next;
        dr_reg <= dr_next;
    end

    // count store and peak
    logic [AW-1:0]         clr_reg, clr_next;
    logic [COUNT_BITS-1:0] peak_reg, peak_next;
    logic [COUNT_BITS-1:0] rd_cnt, inc_cnt;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    assign inc_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
    assign ram_we    = cmd.clr_step || (cmd.nb_write && nb_ok);
    assign ram_waddr = cmd.clr_step ? clr_reg : nb_addr;
    assign ram_wdata = cmd.clr_step ? '0 : inc_cnt;

    always_comb
    begin
        clr_next  = clr_reg;
        peak_next = peak_reg;
        if (cmd.clr_start)
        begin
            clr_next  = '0;
            peak_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_next = clr_reg + 1'b1;
        end
        else if (cmd.nb_write && nb_ok && (inc_cnt > peak_reg))
        begin
            peak_next = inc_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            peak_reg <= '0;
        end
        else
        begin
            clr_reg  <= clr_next;
            peak_reg <= peak_next;
        end
    end

    ncg_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.nb_read),
        .raddr (nb_addr),
        .rdata (rd_cnt)
    );

    // result register
    logic [OUT_CELL_W-1:0] col_out_reg, row_out_reg;
    logic [OUT_PEAK_W-1:0] peak_out_reg;
    logic                  rej_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                OUT_ADD:
                begin
                    col_out_reg  <= qx[OUT_CELL_W-1:0];
                    row_out_reg  <= qy[OUT_CELL_W-1:0];
                    peak_out_reg <= OUT_PEAK_W'(peak_reg);
                    rej_out_reg  <= 1'b0;
                end
                OUT_REJECT:
                begin
                    col_out_reg  <= '0;
                    row_out_reg  <= '0;
                    peak_out_reg <= OUT_PEAK_W'(peak_reg);
                    rej_out_reg  <= 1'b1;
                end
                default:
                begin
                    col_out_reg  <= '0;
                    row_out_reg  <= '0;
                    peak_out_reg <= '0;
                    rej_out_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign cell_col   = col_out_reg;
    assign cell_row   = row_out_reg;
    assign peak_count = peak_out_reg;
    assign rejected   = rej_out_reg;

    assign sts.clr_last = (clr_reg == AW'(DEPTH - 1));
    assign sts.div_done = !busy_x && !busy_y;
    assign sts.reject   = reject;
    assign sts.nb_last  = (dc_reg == 2'd2) && (dr_reg == 2'd2);

`ifndef SYNTHESIS
    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clr_start |=> (peak_reg >= $past(peak_reg)))
        else $error("peak dropped without a clear");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((AW + 1)'(ram_waddr) < (AW + 1)'(DEPTH)))
        else $error("count store written beyond its depth");
`endif

endmodule

FILE: rtl/neighbor_cell_counting_grid.sv
// ---------------------------------------------------------------------------
// neighbor_cell_counting_grid
// 3x3 neighborhood histogram of image points on a configurable grid.
// ---------------------------------------------------------------------------
// An add beat maps the Q12.4 point to a grid cell by dividing its offset from
// the origin by the cell size on each axis, then increments the clipped 3x3
// block of cells around it (counts saturate) and tracks the peak count. Each
// beat returns one result beat with the cell and the peak; a point below the
// origin or outside the bins in use returns rejected with the grid unchanged.
// A clear beat zeroes all counts and the peak. Both axes are divided in
// parallel by the bit-serial dividers, and each neighbor cell takes a
// registered read and then a write back of its count; a rejected point skips
// the neighbor walk. A clear beat runs a clearing pass over all MAX_ROWS *
// MAX_COLS cells, one cell per cycle, and the same pass runs after reset
// with in_stall high; configuration writes are taken at any time but belong
// only to idle periods. A result beat may wait in the output register while
// the next item is already accepted.
// ---------------------------------------------------------------------------
module neighbor_cell_counting_grid
    import ncg_pkg::*;
#(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [POS_W-1:0]      x_pos,
    input  logic [POS_W-1:0]      y_pos,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_CELL_W-1:0] cell_col,
    output logic [OUT_CELL_W-1:0] cell_row,
    output logic [OUT_PEAK_W-1:0] peak_count,
    output logic                  rejected
);

    ncg_cmd_t cmd;
    ncg_sts_t sts;

    ncg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ncg_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .cmd        (cmd),
        .sts        (sts),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .peak_count (peak_count),
        .rejected   (rejected)
    );

endmodule
